/* rtl/htld_pkg.sv */
// ----------------------------------------------------------------------------
// htld_pkg
// Shared types and constants for the hex tag line dedup classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package htld_pkg;

  localparam int TAG_LEN     = 16;
  localparam int TAG_IDX_W   = 4;
  localparam int INNER_W     = 5;
  localparam int LEN_OUT_W   = 9;
  localparam int DROP_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic       ACT_BYTE  = 1'b0;
  localparam logic       ACT_FLUSH = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [3:0] {
    PH_SEEK  = 4'b0001,
    PH_INNER = 4'b0010,
    PH_FOUND = 4'b0100,
    PH_NONE  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    RSN_NO_TAG = 3'd0,
    RSN_FIRST  = 3'd1,
    RSN_EXCEPT = 3'd2,
    RSN_DUP    = 3'd3,
    RSN_NEW    = 3'd4
  } reason_t;

  typedef struct packed {
    logic                        found;
    logic [TAG_LEN-1:0][7:0]     tag;
    logic [LEN_OUT_W-1:0]        length;
  } line_rec_t;

endpackage

`default_nettype wire

/* rtl/htld_front.sv */
// ----------------------------------------------------------------------------
// htld_front
// Byte scanner: counts line bytes, finds the parenthesized tag and emits one
// line record per finished line.
// ----------------------------------------------------------------------------
`default_nettype none

module htld_front #(
  parameter int LINE_MAX = 512
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_action,
  input  wire logic [7:0]         in_text_byte,
  input  wire logic               q_full,
  output logic                    push_valid,
  output htld_pkg::line_rec_t     push_rec
);

  localparam int LEN_W = $clog2(LINE_MAX);

  logic [LEN_W-1:0]                   cnt_r, cnt_nxt, cnt_inc, line_len;
  htld_pkg::phase_t                   phase_r, phase_nxt;
  logic [htld_pkg::INNER_W-1:0]       inner_r, inner_nxt;
  logic [htld_pkg::TAG_LEN-1:0][7:0]  tag_r, tag_nxt;
  logic [LEN_W+htld_pkg::LEN_OUT_W-1:0] len_ext;
  logic                               accept;
  logic                               found;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    inner_nxt  = inner_r;
    tag_nxt    = tag_r;
    push_valid = 1'b0;
    line_len   = cnt_r;
    found      = 1'b0;
    if (accept) begin
      if (in_action == htld_pkg::ACT_FLUSH) begin
        if (cnt_r != '0) begin
          push_valid = 1'b1;
          line_len   = cnt_r;
          found      = (phase_r == htld_pkg::PH_FOUND);
          cnt_nxt    = '0;
          phase_nxt  = htld_pkg::PH_SEEK;
          inner_nxt  = '0;
        end
      end else begin
        case (phase_r)
          htld_pkg::PH_SEEK: begin
            if (in_text_byte == htld_pkg::CH_NUL) begin
              phase_nxt = htld_pkg::PH_NONE;
            end else if (in_text_byte == htld_pkg::CH_OPEN) begin
              phase_nxt = htld_pkg::PH_INNER;
              inner_nxt = '0;
            end
          end
          htld_pkg::PH_INNER: begin
            if (in_text_byte == htld_pkg::CH_NUL) begin
              phase_nxt = htld_pkg::PH_NONE;
            end else if (in_text_byte == htld_pkg::CH_CLOSE) begin
              phase_nxt = (inner_r >= htld_pkg::INNER_W'(htld_pkg::TAG_LEN)) ?
                          htld_pkg::PH_FOUND : htld_pkg::PH_NONE;
            end else if (inner_r < htld_pkg::INNER_W'(htld_pkg::TAG_LEN)) begin
              tag_nxt[inner_r[htld_pkg::TAG_IDX_W-1:0]] = in_text_byte;
              inner_nxt = inner_r + 1'b1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
        cnt_nxt = cnt_inc;
        if (in_text_byte == htld_pkg::CH_NL || cnt_r == LEN_W'(LINE_MAX - 2)) begin
          push_valid = 1'b1;
          line_len   = cnt_inc;
          found      = (phase_nxt == htld_pkg::PH_FOUND);
          cnt_nxt    = '0;
          phase_nxt  = htld_pkg::PH_SEEK;
          inner_nxt  = '0;
        end
      end
    end
  end

  assign len_ext         = {{htld_pkg::LEN_OUT_W{1'b0}}, line_len};
  assign push_rec.found  = found;
  assign push_rec.tag    = tag_r;
  assign push_rec.length = len_ext[htld_pkg::LEN_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= htld_pkg::PH_SEEK;
      inner_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      inner_r <= inner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

`default_nettype wire

/* rtl/htld_queue.sv */
// ----------------------------------------------------------------------------
// htld_queue
// Short FIFO of line records between the scanner and the verdict stage.
// ----------------------------------------------------------------------------
`default_nettype none

module htld_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  input  wire htld_pkg::line_rec_t  push_rec,
  output logic                      full,
  output logic                      head_valid,
  output htld_pkg::line_rec_t       head_rec,
  input  wire logic                 pop
);

  htld_pkg::line_rec_t             mem_r [htld_pkg::QUEUE_DEPTH];
  logic [htld_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [htld_pkg::QPTR_W:0]       count_r, count_nxt;

  assign full       = (count_r == (htld_pkg::QPTR_W+1)'(htld_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({push_valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

/* rtl/htld_back.sv */
// ----------------------------------------------------------------------------
// htld_back
// Verdict stage: compares each line tag (unless all-zero or all-F) with the
// stored tag, counts drops and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module htld_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  wire htld_pkg::line_rec_t         head_rec,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_keep_line,
  output logic [2:0]                       out_verdict_reason,
  output logic [htld_pkg::LEN_OUT_W-1:0]   out_line_length,
  output logic [htld_pkg::DROP_W-1:0]      out_drops_total
);

  logic                               out_valid_r, out_valid_nxt;
  logic                               keep_r, keep_nxt;
  htld_pkg::reason_t                  reason_r, reason_nxt;
  logic [htld_pkg::LEN_OUT_W-1:0]     len_r;
  logic [htld_pkg::TAG_LEN-1:0][7:0]  stored_tag_r, stored_tag_nxt;
  logic                               stored_valid_r, stored_valid_nxt;
  logic [htld_pkg::DROP_W-1:0]        drops_r, drops_nxt;
  logic                               all_zero, all_f;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    all_zero = 1'b1;
    all_f    = 1'b1;
    for (int i = 0; i < htld_pkg::TAG_LEN; i++) begin
      if (head_rec.tag[i] != htld_pkg::CH_ZERO) all_zero = 1'b0;
      if (head_rec.tag[i] != htld_pkg::CH_F)    all_f    = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt    = out_valid_r && out_stall;
    keep_nxt         = 1'b1;
    reason_nxt       = htld_pkg::RSN_NO_TAG;
    stored_tag_nxt   = stored_tag_r;
    stored_valid_nxt = stored_valid_r;
    drops_nxt        = drops_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (!head_rec.found) begin
        reason_nxt       = htld_pkg::RSN_NO_TAG;
        stored_valid_nxt = 1'b0;
      end else if (!stored_valid_r) begin
        reason_nxt       = htld_pkg::RSN_FIRST;
        stored_tag_nxt   = head_rec.tag;
        stored_valid_nxt = 1'b1;
      end else if (all_zero || all_f) begin
        reason_nxt     = htld_pkg::RSN_EXCEPT;
        stored_tag_nxt = head_rec.tag;
      end else if (head_rec.tag == stored_tag_r) begin
        reason_nxt = htld_pkg::RSN_DUP;
        keep_nxt   = 1'b0;
        if (drops_r != '1) begin
          drops_nxt = drops_r + 1'b1;
        end
      end else begin
        reason_nxt     = htld_pkg::RSN_NEW;
        stored_tag_nxt = head_rec.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      stored_valid_r <= 1'b0;
      drops_r        <= '0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      stored_valid_r <= stored_valid_nxt;
      drops_r        <= drops_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stored_tag_r <= stored_tag_nxt;
    if (pop) begin
      keep_r   <= keep_nxt;
      reason_r <= reason_nxt;
      len_r    <= head_rec.length;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_keep_line      = keep_r;
  assign out_verdict_reason = reason_r;
  assign out_line_length    = len_r;
  assign out_drops_total    = drops_r;

endmodule

`default_nettype wire

/* rtl/hex_tag_line_dedup_classifier_core.sv */
// ----------------------------------------------------------------------------
// hex_tag_line_dedup_classifier_core
// Top level: byte scanner, record queue and verdict stage.
// ----------------------------------------------------------------------------
// Takes one text byte per clock while in_stall is low and gives one
// keep/drop verdict per finished line. A line ends at a newline, after
// LINE_MAX-1 bytes, or at a flush of a non-empty partial line. The scanner
// handles every byte as it is accepted. A finished line enters a four-entry
// record queue. When the output register is free, the verdict passes from
// the record queue into the output register and then appears on the out_
// ports. The input stalls only when the queue is full. That happens only
// when the output side stalls.
`default_nettype none

module hex_tag_line_dedup_classifier_core #(
  parameter int LINE_MAX = 512
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_action,
  input  wire logic [7:0]                 in_text_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_keep_line,
  output logic [2:0]                      out_verdict_reason,
  output logic [htld_pkg::LEN_OUT_W-1:0]  out_line_length,
  output logic [htld_pkg::DROP_W-1:0]     out_drops_total
);

  logic                 q_full;
  logic                 push_valid;
  htld_pkg::line_rec_t  push_rec;
  logic                 head_valid;
  htld_pkg::line_rec_t  head_rec;
  logic                 pop;

  htld_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_rec     (push_rec)
  );

  htld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  htld_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_rec           (head_rec),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_keep_line      (out_keep_line),
    .out_verdict_reason (out_verdict_reason),
    .out_line_length    (out_line_length),
    .out_drops_total    (out_drops_total)
  );

  a_drop_is_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_keep_line |-> out_verdict_reason == htld_pkg::RSN_DUP)
    else $error("dropped line without duplicate reason");

  a_dup_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict_reason == htld_pkg::RSN_DUP |-> out_drops_total != '0)
    else $error("duplicate shown with zero drop count");

  a_drops_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> out_drops_total >= $past(out_drops_total))
    else $error("drop count went down");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_length != '0 || LINE_MAX > 512)
    else $error("line result with zero length");

endmodule

`default_nettype wire
